/* sv/nsa_pkg.sv */
// package: sizes, payload types and helpers of the switch allocator
`timescale 1ns / 1ps
package nsa_pkg;
    localparam int NUM_IN_PORTS  = 5;
    localparam int NUM_OUT_PORTS = 5;
    localparam int NUM_VCS       = 16;
    localparam int VCS_PER_VNET  = 4;
    localparam int NUM_ENTRIES   = NUM_IN_PORTS * NUM_VCS;
    localparam int IP_W  = (NUM_IN_PORTS  > 1) ? $clog2(NUM_IN_PORTS)  : 1;
    localparam int OP_W  = (NUM_OUT_PORTS > 1) ? $clog2(NUM_OUT_PORTS) : 1;
    localparam int VC_W  = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam logic [31:0] AGE_NEVER = 32'hFFFF_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [2:0]  in_port;
        logic [3:0]  vc_index;
        logic        request;
        logic        has_credit;
        logic [2:0]  route_port;
        logic [31:0] enqueue_time;
        logic [3:0]  target_vc;
        logic        flit_is_tail;
    } in_beat_t;

    typedef struct packed {
        logic       grant_valid;
        logic [2:0] grant_out_port;
        logic [2:0] grant_in_port;
        logic [3:0] grant_in_vc;
        logic [3:0] grant_out_vc;
        logic       vc_freed;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic [3:0]  vc;
        logic        req;
        logic        cred;
        logic [2:0]  route;
        logic [31:0] age;
    } vc_view_t;

    function automatic logic [IDX_W-1:0] entry_idx(input logic [IP_W-1:0] ip,
                                                   input logic [VC_W-1:0] vc);
        entry_idx = IDX_W'(int'(ip) * NUM_VCS + int'(vc));
    endfunction
endpackage

/* sv/nsa_vc_scan.sv */
// per-cycle vc candidate check for one input port against its vnet siblings
`timescale 1ns / 1ps
module nsa_vc_scan
    import nsa_pkg::*;
(
    input  logic [3:0]     ordered_vnet_mask,
    input  logic [VC_W-1:0] vc,
    input  logic           req [VCS_PER_VNET],
    input  logic [2:0]     route [VCS_PER_VNET],
    input  logic [31:0]    age [VCS_PER_VNET],
    input  logic           sib_ok [VCS_PER_VNET],
    input  logic [2:0]     own_route,
    input  logic [31:0]    own_age,
    output logic           is_cand
);
    logic ordered;
    logic blocked;
    int   vnet;
    always_comb
    begin
        vnet    = int'(vc) / VCS_PER_VNET;
        ordered = (vnet < 4) ? ordered_vnet_mask[vnet[1:0]] : 1'b0;
        blocked = 1'b0;
        for (int k = 0; k < VCS_PER_VNET; k++)
        begin
            if (sib_ok[k] && req[k] && route[k] == own_route && age[k] < own_age)
                blocked = 1'b1;
        end
        is_cand = !ordered || !blocked;
    end
endmodule

/* sv/noc_separable_switch_allocator_core.sv */
// top level: separable input-first round-robin switch allocator
//  channel | signals                         | beat
//  in      | in_valid, in_ready, in_data     | entry write or tick
//  out     | out_valid, out_ready, out_data  | one grant per output port
//  cfg     | cfg_we, cfg_wdata               | ordered vnet mask
// after reset a clearing pass writes all NUM_ENTRIES entries, one per cycle
// a tick loads one input port's vcs from the entry store, then checks one vc per
// cycle on the shared candidate unit until the first hit or the last vc, for each
// of the 5 input ports, then sends one beat per output port, each held back while
// out_ready stays low
`timescale 1ns / 1ps
module noc_separable_switch_allocator_core
    import nsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data,
    input  logic      cfg_we,
    input  logic [3:0] cfg_wdata
);
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOAD, S_SCAN, S_OUT} state_t;
    state_t state_reg;

    // entry store: one read and one write address per cycle, registered read
    logic        req_mem   [NUM_ENTRIES];
    logic        cred_mem  [NUM_ENTRIES];
    logic [2:0]  route_mem [NUM_ENTRIES];
    logic [31:0] age_mem   [NUM_ENTRIES];
    logic [3:0]  ovc_mem   [NUM_ENTRIES];
    logic        tail_mem  [NUM_ENTRIES];
    logic        rd_req_reg;
    logic        rd_cred_reg;
    logic [2:0]  rd_route_reg;
    logic [31:0] rd_age_reg;
    logic [3:0]  rd_ovc_reg;
    logic        rd_tail_reg;

    logic [VC_W-1:0] iptr_reg [NUM_IN_PORTS];
    logic [IP_W-1:0] optr_reg [NUM_OUT_PORTS];
    logic [3:0]  mask_reg;

    // local copy of the vcs of the input port being scanned
    logic        b_req_reg   [NUM_VCS];
    logic        b_cred_reg  [NUM_VCS];
    logic [2:0]  b_route_reg [NUM_VCS];
    logic [31:0] b_age_reg   [NUM_VCS];
    logic [3:0]  b_ovc_reg   [NUM_VCS];
    logic        b_tail_reg  [NUM_VCS];

    // first stage results per input port
    logic            found_reg     [NUM_IN_PORTS];
    logic [VC_W-1:0] win_reg       [NUM_IN_PORTS];
    logic [2:0]      win_route_reg [NUM_IN_PORTS];
    logic [3:0]      win_ovc_reg   [NUM_IN_PORTS];
    logic            win_tail_reg  [NUM_IN_PORTS];
    logic [VC_W-1:0] cur_reg       [NUM_IN_PORTS];

    logic [IDX_W-1:0] clr_reg;   // entry being cleared after reset
    logic [VC_W:0]   ld_reg;     // next vc to read from the store
    logic            rd_pend_reg;
    logic [VC_W-1:0] rd_vc_reg;
    logic [IP_W-1:0] sip_reg;  // input port being scanned
    logic [VC_W:0]   it_reg;   // vcs scanned at this port
    logic [OP_W-1:0] op_reg;
    logic            ob_valid_reg;
    out_beat_t       ob_reg;

    logic            in_fire;
    logic            out_step;
    logic [IDX_W-1:0] r_idx;

    // store write port
    logic            w_all;
    logic            w_req_en;
    logic            w_age_en;
    logic [IDX_W-1:0] w_idx;
    logic            w_req;
    logic            w_cred;
    logic [2:0]      w_route;
    logic [31:0]     w_age;
    logic [3:0]      w_ovc;
    logic            w_tail;

    // shared candidate unit on the current vc of port sip_reg
    logic [VC_W-1:0] cvc;
    logic            s_req [VCS_PER_VNET];
    logic [2:0]      s_route [VCS_PER_VNET];
    logic [31:0]     s_age [VCS_PER_VNET];
    logic            s_ok [VCS_PER_VNET];
    logic            is_cand;
    logic            hit;

    // second stage arbitration for port op_reg
    logic            g_found;
    logic [IP_W-1:0] g_ip;
    logic [IDX_W-1:0] gidx;

    assign in_ready  = (state_reg == S_IDLE) && !ob_valid_reg;
    assign out_valid = ob_valid_reg;
    assign out_data  = ob_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_step  = (state_reg == S_OUT) && (!ob_valid_reg || out_ready);
    assign r_idx     = entry_idx(sip_reg, VC_W'(ld_reg));

    always_comb
    begin
        int base;
        cvc  = VC_W'((int'(cur_reg[sip_reg]) + 1) % NUM_VCS);
        base = (int'(cvc) / VCS_PER_VNET) * VCS_PER_VNET;
        for (int k = 0; k < VCS_PER_VNET; k++)
        begin
            s_ok[k]    = (base + k) < NUM_VCS;
            s_req[k]   = 1'b0;
            s_route[k] = '0;
            s_age[k]   = '0;
            if (s_ok[k])
            begin
                s_req[k]   = b_req_reg[VC_W'(base + k)];
                s_route[k] = b_route_reg[VC_W'(base + k)];
                s_age[k]   = b_age_reg[VC_W'(base + k)];
            end
        end
    end

    nsa_vc_scan u_scan (
        .ordered_vnet_mask(mask_reg), .vc(cvc), .req(s_req), .route(s_route),
        .age(s_age), .sib_ok(s_ok), .own_route(b_route_reg[cvc]),
        .own_age(b_age_reg[cvc]), .is_cand(is_cand)
    );

    assign hit = b_req_reg[cvc] && b_cred_reg[cvc] &&
                 (int'(b_route_reg[cvc]) < NUM_OUT_PORTS) && is_cand;

    always_comb
    begin
        int p;
        g_found = 1'b0;
        g_ip    = '0;
        p = int'(optr_reg[op_reg]);
        for (int it = 0; it < NUM_IN_PORTS; it++)
        begin
            p = (p == NUM_IN_PORTS - 1) ? 0 : p + 1;
            if (!g_found && found_reg[p] && int'(win_route_reg[p]) == int'(op_reg))
            begin
                g_found = 1'b1;
                g_ip    = IP_W'(p);
            end
        end
    end
    assign gidx = entry_idx(g_ip, win_reg[g_ip]);

    // store writes: clearing pass, entry write, or grant bookkeeping
    always_comb
    begin
        w_all    = 1'b0;
        w_req_en = 1'b0;
        w_age_en = 1'b0;
        w_idx    = '0;
        w_req    = 1'b0;
        w_cred   = 1'b0;
        w_route  = '0;
        w_age    = AGE_NEVER;
        w_ovc    = '0;
        w_tail   = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            w_all = 1'b1;
            w_idx = clr_reg;
        end
        else if (in_fire && in_data.operation == OP_WRITE &&
                 int'(in_data.in_port) < NUM_IN_PORTS &&
                 int'(in_data.vc_index) < NUM_VCS)
        begin
            w_all   = 1'b1;
            w_idx   = entry_idx(IP_W'(in_data.in_port), VC_W'(in_data.vc_index));
            w_req   = in_data.request;
            w_cred  = in_data.has_credit;
            w_route = in_data.route_port;
            w_age   = in_data.enqueue_time;
            w_ovc   = in_data.target_vc;
            w_tail  = in_data.flit_is_tail;
        end
        else if (out_step && g_found)
        begin
            // grant drops the request; a tail also retires the age
            w_req_en = 1'b1;
            w_age_en = win_tail_reg[g_ip];
            w_idx    = gidx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_all)
        begin
            cred_mem[w_idx]  <= w_cred;
            route_mem[w_idx] <= w_route;
            ovc_mem[w_idx]   <= w_ovc;
            tail_mem[w_idx]  <= w_tail;
        end
        if (w_all || w_req_en)
            req_mem[w_idx] <= w_req;
        if (w_all || w_age_en)
            age_mem[w_idx] <= w_age;
        rd_req_reg   <= req_mem[r_idx];
        rd_cred_reg  <= cred_mem[r_idx];
        rd_route_reg <= route_mem[r_idx];
        rd_age_reg   <= age_mem[r_idx];
        rd_ovc_reg   <= ovc_mem[r_idx];
        rd_tail_reg  <= tail_mem[r_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ob_valid_reg <= 1'b0;
            ob_reg       <= '0;
            mask_reg     <= '0;
            clr_reg      <= '0;
            ld_reg       <= '0;
            rd_pend_reg  <= 1'b0;
            rd_vc_reg    <= '0;
            sip_reg      <= '0;
            it_reg       <= '0;
            op_reg       <= '0;
            for (int i = 0; i < NUM_VCS; i++)
            begin
                b_req_reg[i]   <= 1'b0;
                b_cred_reg[i]  <= 1'b0;
                b_route_reg[i] <= '0;
                b_age_reg[i]   <= AGE_NEVER;
                b_ovc_reg[i]   <= '0;
                b_tail_reg[i]  <= 1'b0;
            end
            for (int i = 0; i < NUM_IN_PORTS; i++)
            begin
                iptr_reg[i]      <= '0;
                found_reg[i]     <= 1'b0;
                win_reg[i]       <= '0;
                win_route_reg[i] <= '0;
                win_ovc_reg[i]   <= '0;
                win_tail_reg[i]  <= 1'b0;
                cur_reg[i]       <= '0;
            end
            for (int i = 0; i < NUM_OUT_PORTS; i++)
                optr_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                mask_reg <= cfg_wdata;
            if (ob_valid_reg && out_ready && !out_step)
                ob_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    if (int'(clr_reg) == NUM_ENTRIES - 1)
                        state_reg <= S_IDLE;
                    else
                        clr_reg <= clr_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (in_fire && in_data.operation == OP_TICK)
                    begin
                        for (int i = 0; i < NUM_IN_PORTS; i++)
                        begin
                            cur_reg[i]   <= iptr_reg[i];
                            iptr_reg[i]  <= VC_W'((int'(iptr_reg[i]) + 1) % NUM_VCS);
                            found_reg[i] <= 1'b0;
                        end
                        sip_reg     <= '0;
                        ld_reg      <= '0;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    // read address goes out one cycle, data lands the next
                    rd_pend_reg <= (int'(ld_reg) < NUM_VCS);
                    if (int'(ld_reg) < NUM_VCS)
                    begin
                        ld_reg    <= ld_reg + 1'b1;
                        rd_vc_reg <= VC_W'(ld_reg);
                    end
                    if (rd_pend_reg)
                    begin
                        b_req_reg[rd_vc_reg]   <= rd_req_reg;
                        b_cred_reg[rd_vc_reg]  <= rd_cred_reg;
                        b_route_reg[rd_vc_reg] <= rd_route_reg;
                        b_age_reg[rd_vc_reg]   <= rd_age_reg;
                        b_ovc_reg[rd_vc_reg]   <= rd_ovc_reg;
                        b_tail_reg[rd_vc_reg]  <= rd_tail_reg;
                    end
                    if (int'(ld_reg) == NUM_VCS && rd_pend_reg)
                    begin
                        it_reg    <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // one vc per cycle; stop this port on first hit or after the last vc
                    cur_reg[sip_reg] <= cvc;
                    if (hit)
                    begin
                        found_reg[sip_reg]     <= 1'b1;
                        win_reg[sip_reg]       <= cvc;
                        win_route_reg[sip_reg] <= b_route_reg[cvc];
                        win_ovc_reg[sip_reg]   <= b_ovc_reg[cvc];
                        win_tail_reg[sip_reg]  <= b_tail_reg[cvc];
                    end
                    if (hit || int'(it_reg) == NUM_VCS - 1)
                    begin
                        it_reg <= '0;
                        if (int'(sip_reg) == NUM_IN_PORTS - 1)
                        begin
                            op_reg    <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            sip_reg   <= sip_reg + 1'b1;
                            ld_reg    <= '0;
                            state_reg <= S_LOAD;
                        end
                    end
                    else
                        it_reg <= it_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (out_step)
                    begin
                        ob_valid_reg <= 1'b1;
                        ob_reg.grant_valid    <= g_found;
                        ob_reg.grant_out_port <= 3'(op_reg);
                        ob_reg.grant_in_port  <= g_found ? 3'(g_ip) : 3'd0;
                        ob_reg.grant_in_vc    <= g_found ? 4'(win_reg[g_ip]) : 4'd0;
                        ob_reg.grant_out_vc   <= g_found ? win_ovc_reg[g_ip] : 4'd0;
                        ob_reg.vc_freed       <= g_found ? win_tail_reg[g_ip] : 1'b0;
                        ob_reg.last           <= (int'(op_reg) == NUM_OUT_PORTS - 1);
                        optr_reg[op_reg] <= (int'(optr_reg[op_reg]) == NUM_IN_PORTS - 1) ?
                                            '0 : optr_reg[op_reg] + 1'b1;
                        if (int'(op_reg) == NUM_OUT_PORTS - 1)
                            state_reg <= S_IDLE;
                        else
                            op_reg <= op_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
